// ----- sv/pidt_pkg.sv -----
// Package: widths, outcome and request codes for the process id table engine.
`timescale 1ns / 1ps
`default_nettype none
package pidt_pkg;
  localparam int unsigned TableSlots = 128;
  localparam int unsigned SlotW      = $clog2(TableSlots);
  localparam int unsigned IdW        = 15;
  localparam int unsigned StatW      = 32;
  localparam int unsigned CountW     = $clog2(TableSlots + 1);
  localparam logic [IdW-1:0] IdLowest  = IdW'(2);
  localparam logic [IdW-1:0] IdHighest = IdW'(32767);
  localparam logic [IdW-1:0] BootId    = IdW'(1);
  localparam int unsigned MaxSteps   = 2 * TableSlots + 5;
  localparam int unsigned StepW      = $clog2(MaxSteps + 1);

  typedef enum logic [2:0] {
    REQ_ALLOC = 3'd0, REQ_UNALLOC = 3'd1, REQ_DETACH = 3'd2,
    REQ_EXIT = 3'd3, REQ_JOIN = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    OUT_OK = 3'd0, OUT_FULL = 3'd1, OUT_INVALID = 3'd2,
    OUT_NOSUCH = 3'd3, OUT_SELF = 3'd4, OUT_NOTEXITED = 3'd5
  } outcome_e;

  // Packed slot entry kept in memory
  typedef struct packed {
    logic [IdW-1:0] owner;
    logic [IdW-1:0] parent;
    logic           exited;
    logic           detached;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  function automatic logic [IdW-1:0] advance_id(input logic [IdW-1:0] id);
    logic [IdW:0] n;
    n = {1'b0, id} + (IdW+1)'(1);
    if (n > {1'b0, IdHighest} || n < {1'b0, IdLowest}) begin
      return IdLowest;
    end
    return n[IdW-1:0];
  endfunction
endpackage
`default_nettype wire

// ----- sv/pidt_if.sv -----
// Interfaces: request and result channels.
`timescale 1ns / 1ps
`default_nettype none
interface pidt_req_if;
  import pidt_pkg::*;
  logic           valid;
  logic           ready;
  logic [2:0]     req_type;
  logic [IdW-1:0] caller_id;
  logic [IdW-1:0] target_id;
  logic signed [StatW-1:0] exit_value;
  logic           no_wait;
  modport source (output valid, req_type, caller_id, target_id, exit_value, no_wait,
                  input ready);
  modport sink (input valid, req_type, caller_id, target_id, exit_value, no_wait,
                output ready);
endinterface

interface pidt_res_if;
  import pidt_pkg::*;
  logic           valid;
  logic           ready;
  logic [2:0]     outcome;
  logic [IdW-1:0] granted_id;
  logic signed [StatW-1:0] reported_status;
  modport source (output valid, outcome, granted_id, reported_status, input ready);
  modport sink (input valid, outcome, granted_id, reported_status, output ready);
endinterface
`default_nettype wire

// ----- sv/pidt_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module pidt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write or read one word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// ----- sv/process_id_table_engine.sv -----
// Top level: process id table engine with sequencer and slot memories.
//
// Usage: requests arrive on req (valid/ready), one result per request leaves
// on res (valid/ready). One request is handled at a time: ready is high only
// while the sequencer is idle and the result register is free.
// Sequence: join, exit, detach and unallocate pass through accept, memory
// read, decide and write, result. Allocate checks one slot at a time
// against the used bits, with a wait state between probes, and skips at
// most 2*slots+5 used slots before it reports full.
// Slot used bits are flip-flops that reset to the boot slot alone; an entry
// whose used bit is clear reads as free with zero fields. After reset only the
// boot slot is used. No clearing pass is needed.
// When the receiver stalls, the result is held in the output register and
// no new request is taken until it is delivered.
`timescale 1ns / 1ps
`default_nettype none
module process_id_table_engine
  import pidt_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pidt_req_if.sink    req,
  pidt_res_if.source  res
);
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRead  = 3'd1;
  localparam logic [2:0] StEval  = 3'd2;
  localparam logic [2:0] StProbe = 3'd3;
  localparam logic [2:0] StPWait = 3'd4;

  localparam logic [SlotW-1:0] BootSlot = BootId[SlotW-1:0];

  logic [2:0]       state_q, state_d;
  logic [TableSlots-1:0] used_q, used_d;
  logic [CountW-1:0] live_q, live_d;
  logic [IdW-1:0]   cand_q, cand_d;
  logic [StepW-1:0] steps_q, steps_d;
  logic [2:0]       rt_q;
  logic [IdW-1:0]   caller_q, target_q;
  logic [StatW-1:0] value_q;
  logic             rv_q, rv_d;
  logic [2:0]       ro_q, ro_d;
  logic [IdW-1:0]   rg_q, rg_d;
  logic [StatW-1:0] rs_q, rs_d;

  logic             we;
  logic [SlotW-1:0] addr;
  entry_t           wentry, rentry_raw;
  logic [StatW-1:0] wstat, rstat;
  logic             swe;
  logic             accept;

  pidt_ram #(.Width(EntryW), .Depth(TableSlots)) u_entry (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wentry), .rdata_o(rentry_raw));
  pidt_ram #(.Width(StatW), .Depth(TableSlots)) u_stat (
    .clk_i, .we_i(swe), .addr_i(addr), .wdata_i(wstat), .rdata_o(rstat));

  assign accept    = req.valid && req.ready;
  assign req.ready = (state_q == StIdle) && !rv_q;
  assign res.valid = rv_q;
  assign res.outcome = ro_q;
  assign res.granted_id = rg_q;
  assign res.reported_status = rs_q;

  logic [SlotW-1:0] addr_q;
  logic             boot_raw_q;
  logic             boot_raw_d;

  // Next state, result, table update, address and write control
  always_comb begin
    entry_t cur;
    logic found;
    state_d = state_q;
    used_d = used_q;
    live_d = live_q;
    cand_d = cand_q;
    steps_d = steps_q;
    rv_d = rv_q && !res.ready;
    ro_d = ro_q;
    rg_d = rg_q;
    rs_d = rs_q;
    we = 1'b0;
    swe = 1'b0;
    wentry = '0;
    wstat = '0;
    boot_raw_d = boot_raw_q;
    addr = addr_q;
    cur = entry_t'(rentry_raw);
    if (!used_q[addr_q]) begin
      cur = '0;
    end else if (addr_q == BootSlot && boot_raw_q) begin
      cur = '{owner: BootId, parent: '0, exited: 1'b0, detached: 1'b0};
    end
    found = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (req.req_type == REQ_EXIT) addr = req.caller_id[SlotW-1:0];
          else if (req.req_type == REQ_ALLOC) addr = cand_q[SlotW-1:0];
          else addr = req.target_id[SlotW-1:0];
          steps_d = '0;
          state_d = (req.req_type == REQ_ALLOC) ? StProbe : StRead;
        end
      end
      StRead: begin
        state_d = StEval;
      end
      StEval: begin
        state_d = StIdle;
        rv_d = 1'b1;
        ro_d = OUT_INVALID;
        rg_d = '0;
        rs_d = '0;
        found = used_q[addr_q] && cur.owner == ((rt_q == REQ_EXIT) ? caller_q : target_q);
        case (rt_q)
          REQ_UNALLOC: begin
            if (target_q < IdLowest || target_q > IdHighest) ro_d = OUT_INVALID;
            else if (!found) ro_d = OUT_NOSUCH;
            else if (cur.exited || cur.parent != caller_q) ro_d = OUT_INVALID;
            else begin
              ro_d = OUT_OK;
              used_d[addr_q] = 1'b0;
              live_d = live_q - CountW'(1);
            end
          end
          REQ_DETACH: begin
            if (target_q == '0 || target_q == BootId) ro_d = OUT_INVALID;
            else if (!found) ro_d = OUT_NOSUCH;
            else if (cur.detached || cur.parent != caller_q) ro_d = OUT_INVALID;
            else begin
              ro_d = OUT_OK;
              if (cur.exited) begin
                used_d[addr_q] = 1'b0;
                live_d = live_q - CountW'(1);
              end else begin
                we = 1'b1;
                wentry = cur;
                wentry.detached = 1'b1;
                if (addr_q == BootSlot) boot_raw_d = 1'b0;
              end
            end
          end
          REQ_EXIT: begin
            if (!found) ro_d = OUT_NOSUCH;
            else begin
              ro_d = OUT_OK;
              if (cur.detached) begin
                used_d[addr_q] = 1'b0;
                if (live_q != '0) live_d = live_q - CountW'(1);
              end else begin
                we = 1'b1;
                swe = 1'b1;
                wstat = value_q;
                wentry = cur;
                wentry.exited = 1'b1;
                wentry.parent = '0;
                if (addr_q == BootSlot) boot_raw_d = 1'b0;
              end
            end
          end
          REQ_JOIN: begin
            if (target_q == '0 || target_q == BootId || target_q < IdLowest ||
                target_q > IdHighest) ro_d = OUT_INVALID;
            else if (target_q == caller_q) ro_d = OUT_SELF;
            else if (!found) ro_d = OUT_NOSUCH;
            else if (cur.detached) ro_d = OUT_INVALID;
            else if (!cur.exited) ro_d = OUT_NOTEXITED;
            else begin
              ro_d = OUT_OK;
              rg_d = target_q;
              rs_d = rstat;
            end
          end
          default: ro_d = OUT_INVALID;
        endcase
      end
      StProbe: begin
        // Check request-level guards first, then the probed slot
        if (rt_q != REQ_ALLOC || caller_q == '0) begin
          state_d = StIdle; rv_d = 1'b1; ro_d = OUT_INVALID; rg_d = '0; rs_d = '0;
        end else if (live_q >= CountW'(TableSlots) || steps_q == StepW'(MaxSteps)) begin
          state_d = StIdle; rv_d = 1'b1; ro_d = OUT_FULL; rg_d = '0; rs_d = '0;
        end else if (!used_q[cand_q[SlotW-1:0]]) begin
          state_d = StIdle; rv_d = 1'b1; ro_d = OUT_OK; rg_d = cand_q; rs_d = '0;
          used_d[cand_q[SlotW-1:0]] = 1'b1;
          live_d = live_q + CountW'(1);
          cand_d = advance_id(cand_q);
          addr = cand_q[SlotW-1:0];
          we = 1'b1;
          wentry = '{owner: cand_q, parent: caller_q, exited: 1'b0, detached: 1'b0};
          if (cand_q[SlotW-1:0] == BootSlot) boot_raw_d = 1'b0;
        end else begin
          cand_d = advance_id(cand_q);
          steps_d = steps_q + StepW'(1);
          state_d = StPWait;
        end
      end
      StPWait: begin
        state_d = StProbe;
      end
      default: state_d = StIdle;
    endcase
  end

  // Control and table state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      used_q <= TableSlots'(1) << BootSlot;
      live_q <= CountW'(1);
      cand_q <= IdLowest;
      steps_q <= '0;
      rv_q <= 1'b0;
      boot_raw_q <= 1'b1;
    end else begin
      state_q <= state_d;
      used_q <= used_d;
      live_q <= live_d;
      cand_q <= cand_d;
      steps_q <= steps_d;
      rv_q <= rv_d;
      boot_raw_q <= boot_raw_d;
    end
  end

  // Request, address and result payload
  always_ff @(posedge clk_i) begin
    addr_q <= addr;
    ro_q <= ro_d;
    rg_q <= rg_d;
    rs_q <= rs_d;
    if (accept) begin
      rt_q <= req.req_type;
      caller_q <= req.caller_id;
      target_q <= req.target_id;
      value_q <= req.exit_value;
    end
  end
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for the process id table engine: directed table, then random traffic.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import pidt_pkg::*;

  typedef struct {
    req_e                    kind;
    logic [IdW-1:0]          caller;
    logic [IdW-1:0]          target;
    logic signed [StatW-1:0] value;
    logic                    nowait;
    logic                    fixed;
    outcome_e                want_out;
    logic [IdW-1:0]          want_id;
    logic signed [StatW-1:0] want_stat;
  } row_t;

  typedef struct {
    outcome_e                outc;
    logic [IdW-1:0]          id;
    logic signed [StatW-1:0] stat;
  } answer_t;

  logic clk_i;
  logic rst_ni;
  pidt_req_if req_ch ();
  pidt_res_if res_ch ();

  process_id_table_engine i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch.sink),
    .res    (res_ch.source)
  );

  // Shadow copy of the table
  logic                    tab_used   [TableSlots];
  logic [IdW-1:0]          tab_owner  [TableSlots];
  logic [IdW-1:0]          tab_parent [TableSlots];
  logic                    tab_exited [TableSlots];
  logic                    tab_det    [TableSlots];
  logic signed [StatW-1:0] tab_stat   [TableSlots];
  logic [IdW-1:0]          cand_id;
  int unsigned             live_ids;

  answer_t     pending_answers[$];
  int unsigned mismatches;
  int unsigned sent_cnt;
  int unsigned got_cnt;
  int unsigned cycle_cnt;
  logic        hold_off;
  logic [IdW-1:0] known_ids[$];

  function automatic int unsigned slot_of(logic [IdW-1:0] id);
    return int'(id) % TableSlots;
  endfunction

  function automatic logic [IdW-1:0] next_id(logic [IdW-1:0] id);
    int n;
    n = int'(id) + 1;
    if (n > int'(IdHighest) || n < int'(IdLowest)) return IdLowest;
    return IdW'(n);
  endfunction

  task automatic clear_table;
    for (int i = 0; i < TableSlots; i++) begin
      tab_used[i] = 0; tab_owner[i] = '0; tab_parent[i] = '0;
      tab_exited[i] = 0; tab_det[i] = 0; tab_stat[i] = '0;
    end
    tab_used[slot_of(BootId)] = 1;
    tab_owner[slot_of(BootId)] = BootId;
    cand_id = IdLowest;
    live_ids = 1;
  endtask

  task automatic release_slot(int unsigned s);
    tab_used[s] = 0; tab_owner[s] = '0; tab_parent[s] = '0;
    tab_exited[s] = 0; tab_det[s] = 0; tab_stat[s] = '0;
    if (live_ids > 0) live_ids--;
  endtask

  function automatic logic present(logic [IdW-1:0] id);
    return tab_used[slot_of(id)] && tab_owner[slot_of(id)] == id;
  endfunction

  // Work out the answer to one request and update the shadow table
  task automatic predict_answer(input row_t r, output answer_t a);
    int unsigned s, steps;
    logic [IdW-1:0] c;
    logic found;
    a.outc = OUT_INVALID; a.id = '0; a.stat = '0;
    case (r.kind)
      REQ_ALLOC: begin
        if (r.caller != 0) begin
          a.outc = OUT_FULL;
          if (live_ids < TableSlots) begin
            c = cand_id; steps = 0; found = 0;
            while (steps < MaxSteps) begin
              if (!tab_used[slot_of(c)]) begin
                found = 1;
                break;
              end
              c = next_id(c);
              steps++;
            end
            if (found) begin
              s = slot_of(c);
              tab_used[s] = 1; tab_owner[s] = c; tab_parent[s] = r.caller;
              tab_exited[s] = 0; tab_det[s] = 0; tab_stat[s] = '0;
              live_ids++;
              cand_id = next_id(c);
              a.outc = OUT_OK; a.id = c;
              known_ids.push_back(c);
            end
          end
        end
      end
      REQ_UNALLOC: begin
        s = slot_of(r.target);
        if (r.target >= IdLowest && r.target <= IdHighest) begin
          if (!present(r.target)) a.outc = OUT_NOSUCH;
          else if (!tab_exited[s] && tab_parent[s] == r.caller) begin
            release_slot(s);
            a.outc = OUT_OK;
          end
        end
      end
      REQ_DETACH: begin
        s = slot_of(r.target);
        if (r.target != 0 && r.target != BootId) begin
          if (!present(r.target)) a.outc = OUT_NOSUCH;
          else if (!tab_det[s] && tab_parent[s] == r.caller) begin
            if (tab_exited[s]) release_slot(s);
            else tab_det[s] = 1;
            a.outc = OUT_OK;
          end
        end
      end
      REQ_EXIT: begin
        s = slot_of(r.caller);
        if (!present(r.caller)) a.outc = OUT_NOSUCH;
        else begin
          tab_stat[s] = r.value; tab_exited[s] = 1; tab_parent[s] = '0;
          if (tab_det[s]) release_slot(s);
          a.outc = OUT_OK;
        end
      end
      REQ_JOIN: begin
        s = slot_of(r.target);
        if (r.target >= IdLowest && r.target <= IdHighest) begin
          if (r.target == r.caller) a.outc = OUT_SELF;
          else if (!present(r.target)) a.outc = OUT_NOSUCH;
          else if (!tab_det[s]) begin
            if (!tab_exited[s]) a.outc = OUT_NOTEXITED;
            else begin
              a.outc = OUT_OK; a.id = r.target; a.stat = tab_stat[s];
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // Clock and cycle limit
  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 5000000) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Verification failed");
      $finish;
    end
  end

  // Long receiver hold-off, timed in cycles once traffic is well under way
  initial begin
    wait (sent_cnt >= 425);
    hold_off = 1;
    repeat (400) @(negedge clk_i);
    hold_off = 0;
  end

  // Result receiver: random stalls, one long hold-off
  initial begin
    res_ch.ready = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off) res_ch.ready <= 0;
      else if ($urandom_range(0, 3) == 0) res_ch.ready <= 0;
      else if ($urandom_range(0, 60) == 0) begin
        res_ch.ready <= 0;
        repeat ($urandom_range(10, 40)) @(negedge clk_i);
        res_ch.ready <= 1;
      end else res_ch.ready <= 1;
    end
  end

  // Compare each delivered result with the oldest expectation
  always @(posedge clk_i) begin
    answer_t e;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got_cnt++;
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result outcome=%0d", res_ch.outcome);
      end else begin
        e = pending_answers.pop_front();
        if (res_ch.outcome !== e.outc || res_ch.granted_id !== e.id ||
            res_ch.reported_status !== e.stat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     e.outc, e.id, e.stat, res_ch.outcome, res_ch.granted_id,
                     res_ch.reported_status);
        end
      end
    end
  end

  // Offer one request and wait for it to be taken
  task automatic send_request(input row_t r);
    answer_t a;
    while ($urandom_range(0, 4) == 0) begin
      req_ch.valid <= 0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 25) : 1) @(negedge clk_i);
    end
    req_ch.valid <= 1;
    req_ch.req_type <= r.kind; req_ch.caller_id <= r.caller;
    req_ch.target_id <= r.target; req_ch.exit_value <= r.value;
    req_ch.no_wait <= r.nowait;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    predict_answer(r, a);
    if (r.fixed && (a.outc !== r.want_out || a.id !== r.want_id || a.stat !== r.want_stat))
      $display("Directed row disagrees with predictor: kind=%0d", r.kind);
    if (r.fixed) begin
      a.outc = r.want_out; a.id = r.want_id; a.stat = r.want_stat;
    end
    pending_answers.push_back(a);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  function automatic row_t mk(req_e k, int c, int t, int v, bit nw);
    row_t r;
    r.kind = k; r.caller = IdW'(c); r.target = IdW'(t); r.value = v; r.nowait = nw;
    r.fixed = 0; r.want_out = OUT_OK; r.want_id = '0; r.want_stat = '0;
    return r;
  endfunction

  function automatic row_t mkx(req_e k, int c, int t, int v, bit nw,
                               outcome_e o, int id, int st);
    row_t r;
    r = mk(k, c, t, v, nw);
    r.fixed = 1; r.want_out = o; r.want_id = IdW'(id); r.want_stat = st;
    return r;
  endfunction

  function automatic logic [IdW-1:0] pick_id();
    int k;
    k = $urandom_range(0, 9);
    if (k < 7 && known_ids.size() > 0)
      return known_ids[$urandom_range(0, known_ids.size() - 1)];
    if (k == 7) return IdW'($urandom_range(0, 3));
    return IdW'($urandom);
  endfunction

  row_t dir_rows[$];

  initial begin
    row_t r;
    int unsigned rk;
    req_ch.valid = 0; req_ch.req_type = '0; req_ch.caller_id = '0;
    req_ch.target_id = '0; req_ch.exit_value = '0; req_ch.no_wait = 0;
    hold_off = 0; mismatches = 0; sent_cnt = 0; got_cnt = 0; cycle_cnt = 0;
    clear_table();
    rst_ni = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // Directed table: after reset, extremes, every request and special case
    dir_rows = '{
      mkx(REQ_ALLOC, 0, 0, 0, 0, OUT_INVALID, 0, 0),
      mkx(REQ_ALLOC, 1, 0, 0, 0, OUT_OK, 2, 0),
      mkx(REQ_ALLOC, 32767, 32767, -1, 1, OUT_OK, 3, 0),
      mkx(req_e'(3'd5), 1, 2, 0, 0, OUT_INVALID, 0, 0),
      mkx(req_e'(3'd7), 32767, 32767, -1, 1, OUT_INVALID, 0, 0),
      mkx(REQ_JOIN, 1, 2, 0, 1, OUT_NOTEXITED, 0, 0),
      mkx(REQ_JOIN, 2, 2, 0, 0, OUT_SELF, 0, 0),
      mkx(REQ_JOIN, 1, 1, 0, 0, OUT_INVALID, 0, 0),
      mkx(REQ_JOIN, 1, 0, 0, 0, OUT_INVALID, 0, 0),
      mkx(REQ_JOIN, 1, 32767, 0, 0, OUT_NOSUCH, 0, 0),
      mkx(REQ_EXIT, 2, 0, 32'sh80000000, 0, OUT_OK, 0, 0),
      mkx(REQ_JOIN, 1, 2, 0, 0, OUT_OK, 2, 32'sh80000000),
      mkx(REQ_EXIT, 2, 0, 32'sh7fffffff, 0, OUT_OK, 0, 0),
      mkx(REQ_JOIN, 1, 2, 0, 1, OUT_OK, 2, 32'sh7fffffff),
      mkx(REQ_UNALLOC, 1, 2, 0, 0, OUT_INVALID, 0, 0),
      mkx(REQ_DETACH, 0, 2, 0, 0, OUT_OK, 0, 0),
      mkx(REQ_EXIT, 2, 0, 5, 0, OUT_NOSUCH, 0, 0),
      mkx(REQ_UNALLOC, 1, 1, 0, 0, OUT_INVALID, 0, 0),
      mkx(REQ_UNALLOC, 5, 3, 0, 0, OUT_INVALID, 0, 0),
      mkx(REQ_DETACH, 1, 1, 0, 0, OUT_INVALID, 0, 0),
      mkx(REQ_DETACH, 32767, 3, 0, 0, OUT_OK, 0, 0),
      mkx(REQ_DETACH, 32767, 3, 0, 0, OUT_INVALID, 0, 0),
      mkx(REQ_JOIN, 1, 3, 0, 0, OUT_INVALID, 0, 0),
      mkx(REQ_EXIT, 3, 0, 9, 0, OUT_OK, 0, 0),
      mkx(REQ_UNALLOC, 1, 3, 0, 0, OUT_NOSUCH, 0, 0)
    };
    foreach (dir_rows[i]) send_request(dir_rows[i]);

    // Random traffic; one run of allocations fills the table to reach the full case
    for (int n = 0; n < 1250; n++) begin
      if (n >= 600 && n < 760) rk = 0;
      else rk = $urandom_range(0, 19);
      if (rk < 7) r = mk(REQ_ALLOC, ($urandom_range(0, 30) == 0) ? 0 : pick_id(), $urandom,
                          $urandom, $urandom_range(0, 1));
      else if (rk < 10) r = mk(REQ_EXIT, pick_id(), $urandom, $urandom, $urandom_range(0, 1));
      else if (rk < 13) r = mk(REQ_JOIN, pick_id(), pick_id(), $urandom, $urandom_range(0, 1));
      else if (rk < 15) r = mk(REQ_DETACH, pick_id(), pick_id(), $urandom,
                               $urandom_range(0, 1));
      else if (rk < 19) r = mk(REQ_UNALLOC, pick_id(), pick_id(), $urandom,
                               $urandom_range(0, 1));
      else r = mk(req_e'(3'($urandom_range(5, 7))), $urandom, $urandom, $urandom, 1);
      // Parent-directed requests: use the real parent most of the time
      if ((r.kind == REQ_UNALLOC || r.kind == REQ_DETACH) && $urandom_range(0, 3) != 0 &&
          present(r.target))
        r.caller = tab_parent[slot_of(r.target)];
      send_request(r);
    end
    req_ch.valid <= 0;

    // Drain, then allow for the longest allocate scan
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (2 * MaxSteps + 20) @(posedge clk_i);
    $display("Sent %0d requests, checked %0d results, table held %0d ids at the end.",
             sent_cnt, got_cnt, live_ids);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
